// ----- hdl/fvtg_pkg.sv -----
// Package for the four-voice tone generator: beat layouts, operation codes
// and the note period table. No dependencies; used by the top level and its checker.
package fvtg_pkg;

    // Operation codes carried in s_axis_tuser.
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    // Default parameter values.
    localparam int DEF_VOICE_COUNT  = 4;
    localparam int DEF_WAVE_LENGTH  = 64;
    localparam int DEF_COUNTER_BITS = 16;

    // Field widths.
    localparam int CHANNEL_BITS  = 2;
    localparam int NOTE_BITS     = 4;
    localparam int OCTAVE_BITS   = 3;
    localparam int TONE_BITS     = 4;
    localparam int WAVE_POS_BITS = 6;
    localparam int PERIOD_BITS   = 14;

    // Input beat layout in s_axis_tdata.
    localparam int IN_CHANNEL_LSB = 0;
    localparam int IN_NOTE_LSB    = IN_CHANNEL_LSB + CHANNEL_BITS;
    localparam int IN_OCTAVE_LSB  = IN_NOTE_LSB + NOTE_BITS;
    localparam int IN_OFF_BIT     = IN_OCTAVE_LSB + OCTAVE_BITS;
    localparam int IN_USED_BITS   = IN_OFF_BIT + 1;
    localparam int IN_DATA_W      = ((IN_USED_BITS + 7) / 8) * 8;

    // Output beat layout in m_axis_tdata.
    localparam int OUT_TONE_LSB  = 0;
    localparam int OUT_WAVE_LSB  = OUT_TONE_LSB + TONE_BITS;
    localparam int OUT_BAD_BIT   = OUT_WAVE_LSB + WAVE_POS_BITS;
    localparam int OUT_USED_BITS = OUT_BAD_BIT + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_BITS + 7) / 8) * 8;

    // Period table: five octave rows (octaves 2 to 6) of twelve semitones.
    localparam int NOTES_PER_ROW = 12;
    localparam int OCTAVE_ROWS   = 5;

    localparam logic [PERIOD_BITS-1:0] PERIOD_TABLE [OCTAVE_ROWS][NOTES_PER_ROW] = '{
        '{14'd8600, 14'd8117, 14'd7662, 14'd7232, 14'd6826, 14'd6443,
          14'd6081, 14'd5740, 14'd5418, 14'd5114, 14'd4827, 14'd4556},
        '{14'd4300, 14'd4059, 14'd3831, 14'd3616, 14'd3413, 14'd3221,
          14'd3041, 14'd2870, 14'd2709, 14'd2557, 14'd2413, 14'd2278},
        '{14'd2150, 14'd2029, 14'd1915, 14'd1808, 14'd1706, 14'd1611,
          14'd1520, 14'd1435, 14'd1354, 14'd1278, 14'd1207, 14'd1139},
        '{14'd1075, 14'd1015, 14'd958,  14'd903,  14'd853,  14'd805,
          14'd760,  14'd717,  14'd677,  14'd639,  14'd603,  14'd569},
        '{14'd538,  14'd507,  14'd479,  14'd452,  14'd427,  14'd403,
          14'd380,  14'd359,  14'd339,  14'd320,  14'd302,  14'd285}
    };

    // True when the note and octave address an entry of the table.
    function automatic logic note_in_range(input logic [NOTE_BITS-1:0] note,
                                           input logic [OCTAVE_BITS-1:0] octave);
        return (note < NOTE_BITS'(NOTES_PER_ROW)) && (octave < OCTAVE_BITS'(OCTAVE_ROWS));
    endfunction

    // Period lookup; out-of-range requests return zero and are never used.
    function automatic logic [PERIOD_BITS-1:0] period_lookup(
        input logic [NOTE_BITS-1:0]   note,
        input logic [OCTAVE_BITS-1:0] octave
    );
        logic [PERIOD_BITS-1:0] period;
        period = '0;
        if (note_in_range(note, octave))
        begin
            period = PERIOD_TABLE[octave][note];
        end
        return period;
    endfunction

endpackage

// ----- hdl/four_voice_tone_generator.sv -----
// Four-voice square-wave tone generator on a shared tick counter.
// Depends on fvtg_pkg for beat layouts, operation codes and the period table.
//
// Usage:
// The slave stream carries commands. s_axis_tuser selects the operation: a tick
// advances the counter by one, a set loads a voice from the note table or, with
// the off flag, stops that voice toggling while its level holds. Every accepted
// beat produces exactly one result beat on the master stream with the four voice
// levels, the wavetable position and an error flag for a set without the off flag
// to a present voice with a note above B or octave row above 4 (changes nothing).
// The state update and the result are registered together at the edge that
// accepts the beat. All voice compares and reloads run side by side, so one beat
// is taken every clock while the receiver keeps taking the results.
// The result register acts as the output stage: a new beat is accepted while a
// result is still waiting as long as the receiver takes that result in the
// same cycle. When the receiver stalls, the result holds and s_axis_tready drops.
// Reset clears the counter, all compare values and periods, silences every voice,
// zeroes the levels and the wave index, and empties the result register.
module four_voice_tone_generator #(
    parameter int VOICE_COUNT  = fvtg_pkg::DEF_VOICE_COUNT,
    parameter int WAVE_LENGTH  = fvtg_pkg::DEF_WAVE_LENGTH,
    parameter int COUNTER_BITS = fvtg_pkg::DEF_COUNTER_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // channel[1:0], note[5:2], octave[8:6], voice_off[9], zero fill above
    input  logic [fvtg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation: 0 = tick, 1 = set a voice
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tone_levels[3:0], wave_position[9:4], bad_request[10], zero fill above
    output logic [fvtg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fvtg_pkg::*;

    localparam int WAVE_BITS = (WAVE_LENGTH > 1) ? $clog2(WAVE_LENGTH) : 1;
    localparam int SUM_BITS  = (COUNTER_BITS > PERIOD_BITS) ? COUNTER_BITS : PERIOD_BITS;
    localparam int EXT_VOICES = (VOICE_COUNT > TONE_BITS) ? VOICE_COUNT : TONE_BITS;

    // Counter plus period, wrapped to the counter width.
    function automatic logic [COUNTER_BITS-1:0] add_period(
        input logic [COUNTER_BITS-1:0] base,
        input logic [PERIOD_BITS-1:0]  period
    );
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(period);
        return sum[COUNTER_BITS-1:0];
    endfunction

    // Voice and counter state.
    logic [COUNTER_BITS-1:0] tick_count_reg, tick_count_next;
    logic [COUNTER_BITS-1:0] compare_reg [VOICE_COUNT];
    logic [COUNTER_BITS-1:0] compare_next [VOICE_COUNT];
    logic [PERIOD_BITS-1:0]  period_reg [VOICE_COUNT];
    logic [PERIOD_BITS-1:0]  period_next [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]  enabled_reg, enabled_next;
    logic [VOICE_COUNT-1:0]  level_reg, level_next;
    logic [WAVE_BITS-1:0]    wave_index_reg, wave_index_next;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic [TONE_BITS-1:0]     out_tone_reg;
    logic [WAVE_POS_BITS-1:0] out_wave_reg;
    logic                     out_bad_reg;

    // Decoded input beat.
    op_t                     op;
    logic [CHANNEL_BITS-1:0] channel;
    logic [NOTE_BITS-1:0]    note;
    logic [OCTAVE_BITS-1:0]  octave;
    logic                    voice_off;
    logic                    accept;
    logic                    channel_ok;
    logic                    request_ok;
    logic                    bad_next;
    logic [COUNTER_BITS-1:0] tick_inc;
    logic [PERIOD_BITS-1:0]  set_period;
    logic [EXT_VOICES-1:0]   level_ext;

    assign op        = op_t'(s_axis_tuser);
    assign channel   = s_axis_tdata[IN_CHANNEL_LSB +: CHANNEL_BITS];
    assign note      = s_axis_tdata[IN_NOTE_LSB +: NOTE_BITS];
    assign octave    = s_axis_tdata[IN_OCTAVE_LSB +: OCTAVE_BITS];
    assign voice_off = s_axis_tdata[IN_OFF_BIT];

    // Take a beat whenever the result register is empty or drains this cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign channel_ok = int'(channel) < VOICE_COUNT;
    assign request_ok = note_in_range(note, octave);
    assign set_period = period_lookup(note, octave);
    assign tick_inc   = tick_count_reg + COUNTER_BITS'(1);

    // Next state of the counter and all voices for the beat being accepted.
    always_comb
    begin
        tick_count_next = tick_count_reg;
        compare_next    = compare_reg;
        period_next     = period_reg;
        enabled_next    = enabled_reg;
        level_next      = level_reg;
        wave_index_next = wave_index_reg;
        bad_next        = 1'b0;
        if (accept)
        begin
            unique case (op)
                OP_TICK:
                begin
                    // The compares test the counter value after the advance.
                    tick_count_next = tick_inc;
                    for (int v = 0; v < VOICE_COUNT; v++)
                    begin
                        if (compare_reg[v] == tick_inc)
                        begin
                            compare_next[v] = add_period(tick_inc, period_reg[v]);
                            if (enabled_reg[v])
                            begin
                                level_next[v] = !level_reg[v];
                            end
                        end
                    end
                    // Voice 0 steps the wavetable even while it is silent.
                    if (compare_reg[0] == tick_inc)
                    begin
                        if (wave_index_reg == WAVE_BITS'(WAVE_LENGTH - 1))
                        begin
                            wave_index_next = '0;
                        end
                        else
                        begin
                            wave_index_next = wave_index_reg + WAVE_BITS'(1);
                        end
                    end
                end
                OP_SET:
                begin
                    // A set for a voice that does not exist is ignored, and so is a set with a bad
                    // note or octave unless it carries the off flag.
                    for (int v = 0; v < VOICE_COUNT; v++)
                    begin
                        if (int'(channel) == v)
                        begin
                            if (voice_off)
                            begin
                                enabled_next[v] = 1'b0;
                            end
                            else if (request_ok)
                            begin
                                period_next[v]  = set_period;
                                compare_next[v] = add_period(tick_count_reg, set_period);
                                enabled_next[v] = 1'b1;
                            end
                        end
                    end
                    bad_next = channel_ok && !voice_off && !request_ok;
                end
                default:
                begin
                    bad_next = 1'b0;
                end
            endcase
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !m_axis_tready);
    assign level_ext      = EXT_VOICES'(level_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            enabled_reg    <= '0;
            level_reg      <= '0;
            wave_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                compare_reg[v] <= '0;
                period_reg[v]  <= '0;
            end
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            compare_reg    <= compare_next;
            period_reg     <= period_next;
            enabled_reg    <= enabled_next;
            level_reg      <= level_next;
            wave_index_reg <= wave_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload, loaded with the state that the accepted beat leaves.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_tone_reg <= level_ext[TONE_BITS-1:0];
            out_wave_reg <= WAVE_POS_BITS'(wave_index_next);
            out_bad_reg  <= bad_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_BITS)'(0), out_bad_reg,
                            out_wave_reg, out_tone_reg};

endmodule

// ----- hdl/fvtg_checker.sv -----
// Port-level checker for the four-voice tone generator, with its bind statement.
// Depends on fvtg_pkg for the beat layouts and operation codes.
module fvtg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [fvtg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fvtg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fvtg_pkg::*;

    logic s_beat;
    logic m_stall;
    logic tick_beat;
    logic set_beat;

    assign s_beat    = s_axis_tvalid && s_axis_tready;
    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign tick_beat = s_beat && (s_axis_tuser == OP_TICK);
    assign set_beat  = s_beat && (s_axis_tuser == OP_SET);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n) m_stall |=> m_axis_tvalid)
        else $error("result beat withdrawn before it was taken");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n) m_stall |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // An empty result stage always takes a new command.
    assert property (@(posedge clk) disable iff (!rst_n) !m_axis_tvalid |-> s_axis_tready)
        else $error("command refused with an empty result stage");

    // A tick never reports a bad request.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_beat |=> (m_axis_tvalid && !m_axis_tdata[OUT_BAD_BIT]))
        else $error("tick produced a bad request flag");

    // A set never moves the levels or the wavetable position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (set_beat && m_axis_tvalid) |=>
            (m_axis_tdata[OUT_BAD_BIT-1:0] == $past(m_axis_tdata[OUT_BAD_BIT-1:0])))
        else $error("set command changed levels or wavetable position");

endmodule

bind four_voice_tone_generator fvtg_checker u_fvtg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
